[sv/kit_pkg.sv]
`timescale 1ns / 1ps

package kit_pkg;

  localparam int FUNC_W   = 2;
  localparam int KIND_W   = 4;
  localparam int PAYLD_W  = 56;
  localparam int EID_W    = 7;
  localparam int STAT_W   = 2;
  localparam int RID_W    = 6;
  localparam int CNT_W    = 7;
  localparam int IN_DW    = 72;
  localparam int OUT_DW   = 16;

  localparam int IN_KIND_LSB  = 0;
  localparam int IN_PAYLD_LSB = 4;
  localparam int IN_CB_BIT    = 60;
  localparam int IN_EID_LSB   = 61;

  localparam logic [FUNC_W-1:0] FN_REGISTER = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INV_ID   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_INV_KEY  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY    = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_ONE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [RID_W-1:0]  result_id;
    logic              is_valid_bit;
    logic              notify;
    logic [CNT_W-1:0]  active_entries;
  } res_t;

endpackage

[sv/keyed_invalidation_table.sv]
`timescale 1ns / 1ps

// Append-only table of keyed entries held in one synchronous memory with a single
// read and a single write port. One transaction is worked on at a time. A register
// transaction writes its new entry, invalidate-by-id reads the entry and then writes
// a valid one back cleared, query only reads the entry, and invalidate-by-key scans
// the entries, reading one entry per cycle through the single read port unless a
// stalled result stream holds the block in the state that needs the output register.
// The results of a key invalidate come out in ascending id order, the last one marked
// by out_tlast. The memory needs no clearing after reset: only entries below the
// registered count are ever used.
module keyed_invalidation_table #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 56
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // Fields from bit 0: kind[3:0], payload[59:4], has_callback[60], entry_id[67:61].
  input  logic [kit_pkg::IN_DW-1:0]    in_tdata,
  // Fields from bit 0: func[1:0].
  input  logic [kit_pkg::FUNC_W-1:0]   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // Fields from bit 0: result_id[5:0], is_valid_bit[6], notify[7], active_entries[14:8].
  output logic [kit_pkg::OUT_DW-1:0]   out_tdata,
  // Fields from bit 0: status[1:0].
  output logic [kit_pkg::STAT_W-1:0]   out_tuser,
  output logic                         out_tlast
);

  localparam int AW       = $clog2(MAX_ENTRIES);
  localparam int EW       = KEY_BITS + 6;
  localparam int KIND_LSB = KEY_BITS;
  localparam int NTF_BIT  = KEY_BITS + 4;
  localparam int VLD_BIT  = KEY_BITS + 5;
  localparam int CW       = kit_pkg::CNT_W;

  logic [EW-1:0] mem [MAX_ENTRIES];

  kit_pkg::state_t state_r, state_nxt;

  logic [kit_pkg::FUNC_W-1:0] func_r;
  logic [kit_pkg::KIND_W-1:0] kind_r;
  logic [KEY_BITS-1:0]        key_r;
  logic                       cb_r;
  logic [kit_pkg::EID_W-1:0]  id_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              active_r, active_nxt;
  logic [AW-1:0]              scan_r, scan_nxt;
  logic                       pend_r, pend_nxt;
  logic [kit_pkg::RID_W-1:0]  pend_id_r, pend_id_nxt;
  logic                       pend_ntf_r, pend_ntf_nxt;
  logic [CW-1:0]              pend_act_r, pend_act_nxt;
  logic [EW-1:0]              rd_data_r;
  logic                       out_valid_r;
  kit_pkg::res_t              out_res_r, out_res_nxt;
  logic                       out_last_r, out_last_nxt;

  logic          in_fire, out_free, out_load;
  logic          rd_en, mem_we;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          hit, scan_end, scan_go, id_oor, full;

  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == kit_pkg::ST_IDLE);
  assign out_free = !out_valid_r || out_tready;

  assign hit = rd_data_r[VLD_BIT] && (rd_data_r[KIND_LSB +: kit_pkg::KIND_W] == kind_r)
               && (rd_data_r[KEY_BITS-1:0] == key_r);
  assign scan_end = ((CW'(scan_r) + CW'(1)) == count_r);
  assign scan_go  = !(hit && pend_r && !out_free);
  assign id_oor   = (id_r >= count_r);
  assign full     = (count_r >= CW'(MAX_ENTRIES));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kit_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            kit_pkg::FN_REGISTER: state_nxt = kit_pkg::ST_REG;
            kit_pkg::FN_INV_KEY: begin
              state_nxt = (count_r == '0) ? kit_pkg::ST_FLUSH : kit_pkg::ST_SCAN;
            end
            default: state_nxt = kit_pkg::ST_ONE;
          endcase
        end
      end
      kit_pkg::ST_REG, kit_pkg::ST_ONE: begin
        if (out_free) state_nxt = kit_pkg::ST_IDLE;
      end
      kit_pkg::ST_SCAN: begin
        if (scan_go && scan_end) state_nxt = kit_pkg::ST_FLUSH;
      end
      kit_pkg::ST_FLUSH: begin
        if (out_free) state_nxt = kit_pkg::ST_IDLE;
      end
      default: state_nxt = kit_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = scan_r;
    mem_we       = 1'b0;
    wr_addr      = scan_r;
    wr_data      = rd_data_r;
    out_load     = 1'b0;
    out_res_nxt  = out_res_r;
    out_last_nxt = 1'b1;
    count_nxt    = count_r;
    active_nxt   = active_r;
    scan_nxt     = scan_r;
    pend_nxt     = pend_r;
    pend_id_nxt  = pend_id_r;
    pend_ntf_nxt = pend_ntf_r;
    pend_act_nxt = pend_act_r;
    case (state_r)
      kit_pkg::ST_IDLE: begin
        scan_nxt = '0;
        pend_nxt = 1'b0;
        if (in_fire) begin
          rd_en = 1'b1;
          rd_addr = (in_tuser == kit_pkg::FN_INV_KEY) ? '0 : in_tdata[kit_pkg::IN_EID_LSB +: AW];
        end
      end
      kit_pkg::ST_REG: begin
        if (out_free) begin
          out_load = 1'b1;
          out_res_nxt = '{status: kit_pkg::STAT_FULL, result_id: '0, is_valid_bit: 1'b0,
                          notify: 1'b0, active_entries: active_r};
          if (!full) begin
            mem_we = 1'b1;
            wr_addr = count_r[AW-1:0];
            wr_data = {1'b1, cb_r, kind_r, key_r};
            count_nxt = count_r + CW'(1);
            active_nxt = active_r + CW'(1);
            out_res_nxt.status = kit_pkg::STAT_OK;
            out_res_nxt.result_id = kit_pkg::RID_W'(count_r);
            out_res_nxt.active_entries = active_r + CW'(1);
          end
        end
      end
      kit_pkg::ST_ONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_res_nxt = '{status: kit_pkg::STAT_RANGE, result_id: '0, is_valid_bit: 1'b0,
                          notify: 1'b0, active_entries: active_r};
          if (!id_oor) begin
            if (func_r == kit_pkg::FN_QUERY) begin
              out_res_nxt.status = kit_pkg::STAT_OK;
              out_res_nxt.is_valid_bit = rd_data_r[VLD_BIT];
            end else if (!rd_data_r[VLD_BIT]) begin
              out_res_nxt.status = kit_pkg::STAT_NONE;
            end else begin
              mem_we = 1'b1;
              wr_addr = id_r[AW-1:0];
              wr_data[VLD_BIT] = 1'b0;
              active_nxt = active_r - CW'(1);
              out_res_nxt.status = kit_pkg::STAT_OK;
              out_res_nxt.result_id = kit_pkg::RID_W'(id_r);
              out_res_nxt.notify = rd_data_r[NTF_BIT];
              out_res_nxt.active_entries = active_r - CW'(1);
            end
          end
        end
      end
      kit_pkg::ST_SCAN: begin
        if (scan_go) begin
          if (hit) begin
            mem_we = 1'b1;
            wr_data[VLD_BIT] = 1'b0;
            active_nxt = active_r - CW'(1);
            if (pend_r) begin
              out_load = 1'b1;
              out_last_nxt = 1'b0;
              out_res_nxt = '{status: kit_pkg::STAT_OK, result_id: pend_id_r,
                              is_valid_bit: 1'b0, notify: pend_ntf_r,
                              active_entries: pend_act_r};
            end
            pend_nxt = 1'b1;
            pend_id_nxt = kit_pkg::RID_W'(scan_r);
            pend_ntf_nxt = rd_data_r[NTF_BIT];
            pend_act_nxt = active_r - CW'(1);
          end
          if (!scan_end) begin
            scan_nxt = scan_r + AW'(1);
            rd_en = 1'b1;
            rd_addr = scan_r + AW'(1);
          end
        end
      end
      kit_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          pend_nxt = 1'b0;
          if (pend_r) begin
            out_res_nxt = '{status: kit_pkg::STAT_OK, result_id: pend_id_r, is_valid_bit: 1'b0,
                            notify: pend_ntf_r, active_entries: pend_act_r};
          end else begin
            out_res_nxt = '{status: kit_pkg::STAT_NONE, result_id: '0, is_valid_bit: 1'b0,
                            notify: 1'b0, active_entries: active_r};
          end
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kit_pkg::ST_IDLE;
      count_r     <= '0;
      active_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_tuser;
      kind_r <= in_tdata[kit_pkg::IN_KIND_LSB +: kit_pkg::KIND_W];
      key_r  <= in_tdata[kit_pkg::IN_PAYLD_LSB +: KEY_BITS];
      cb_r   <= in_tdata[kit_pkg::IN_CB_BIT];
      id_r   <= in_tdata[kit_pkg::IN_EID_LSB +: kit_pkg::EID_W];
    end
    scan_r     <= scan_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_ntf_r <= pend_ntf_nxt;
    pend_act_r <= pend_act_nxt;
    if (out_load) begin
      out_res_r  <= out_res_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_res_r.active_entries, out_res_r.notify,
                       out_res_r.is_valid_bit, out_res_r.result_id};

endmodule

[sv/kit_checker.sv]
`timescale 1ns / 1ps

module kit_checker #(
  parameter int MAX_ENTRIES = 64
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [kit_pkg::OUT_DW-1:0] out_tdata,
  input logic [kit_pkg::STAT_W-1:0] out_tuser,
  input logic                       out_tlast
);

  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:8] <= kit_pkg::CNT_W'(MAX_ENTRIES)))
    else $error("Active count exceeds the table size.");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != kit_pkg::STAT_OK)) |-> (out_tlast && (out_tdata[5:0] == '0)))
    else $error("An error status must be a single final result with id zero.");

  a_bits_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[6] && out_tdata[7]))
    else $error("Query bit and notify bit are both set.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                     && $stable(out_tlast)))
    else $error("Stalled result transaction changed.");

endmodule

bind keyed_invalidation_table kit_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_kit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[bench/tb_keyed_invalidation_table.sv]
`timescale 1ns / 1ps

module tb_keyed_invalidation_table;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_LIMIT = 10;
  localparam int PRESSURE_HOLD = 300;

  typedef struct packed {
    logic [kit_pkg::STAT_W-1:0] status;
    logic [kit_pkg::RID_W-1:0]  rid;
    logic                       vbit;
    logic                       notify;
    logic [kit_pkg::CNT_W-1:0]  active;
    logic                       last;
  } table_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [kit_pkg::IN_DW-1:0]     in_tdata;
  logic [kit_pkg::FUNC_W-1:0]    in_tuser;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [kit_pkg::OUT_DW-1:0]    out_tdata;
  logic [kit_pkg::STAT_W-1:0]    out_tuser;
  logic                          out_tlast;

  logic [kit_pkg::KIND_W-1:0]    tbl_kind[TABLE_DEPTH];
  logic [kit_pkg::PAYLD_W-1:0]   tbl_key[TABLE_DEPTH];
  logic                          tbl_valid[TABLE_DEPTH];
  logic                          tbl_notify[TABLE_DEPTH];
  int unsigned                   tbl_count;
  int unsigned                   tbl_active;

  table_result_t        expected_results[$];
  table_result_t        got_result;
  table_result_t        want_result;

  int                   mismatches;
  int                   results_seen;
  int                   quiet_cycles;
  int                   func_counts[4];
  int                   key_clears;
  int                   full_hits;
  bit                   tx_idle_on;
  bit                   rx_idle_on;
  int                   rx_hold;

  keyed_invalidation_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_result(input logic [kit_pkg::STAT_W-1:0] status,
                                      input logic [kit_pkg::RID_W-1:0] rid,
                                      input logic vbit, input logic notify);
    table_result_t rec;
    rec.status = status;
    rec.rid    = rid;
    rec.vbit   = vbit;
    rec.notify = notify;
    rec.active = tbl_active[kit_pkg::CNT_W-1:0];
    rec.last   = 1'b0;
    expected_results = {expected_results, rec};
  endfunction

  // Applies one accepted transaction to the shadow table and queues its results.
  function automatic void predict_table(input logic [kit_pkg::FUNC_W-1:0] fn,
                                        input logic [kit_pkg::KIND_W-1:0] kind,
                                        input logic [kit_pkg::PAYLD_W-1:0] key,
                                        input logic cb,
                                        input logic [kit_pkg::EID_W-1:0] id);
    int n;
    n = 0;
    case (fn)
      kit_pkg::FN_REGISTER: begin
        if (tbl_count >= TABLE_DEPTH) begin
          push_result(kit_pkg::STAT_FULL, '0, 1'b0, 1'b0);
          full_hits++;
        end else begin
          tbl_kind[tbl_count[kit_pkg::RID_W-1:0]]   = kind;
          tbl_key[tbl_count[kit_pkg::RID_W-1:0]]    = key;
          tbl_valid[tbl_count[kit_pkg::RID_W-1:0]]  = 1'b1;
          tbl_notify[tbl_count[kit_pkg::RID_W-1:0]] = cb;
          tbl_active++;
          push_result(kit_pkg::STAT_OK, tbl_count[kit_pkg::RID_W-1:0], 1'b0, 1'b0);
          tbl_count++;
        end
      end
      kit_pkg::FN_INV_ID: begin
        if (id >= tbl_count) begin
          push_result(kit_pkg::STAT_RANGE, '0, 1'b0, 1'b0);
        end else if (!tbl_valid[id[kit_pkg::RID_W-1:0]]) begin
          push_result(kit_pkg::STAT_NONE, '0, 1'b0, 1'b0);
        end else begin
          tbl_valid[id[kit_pkg::RID_W-1:0]] = 1'b0;
          if (tbl_active > 0) tbl_active--;
          push_result(kit_pkg::STAT_OK, id[kit_pkg::RID_W-1:0], 1'b0,
                      tbl_notify[id[kit_pkg::RID_W-1:0]]);
        end
      end
      kit_pkg::FN_INV_KEY: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_valid[i[kit_pkg::RID_W-1:0]] && tbl_kind[i[kit_pkg::RID_W-1:0]] == kind &&
              tbl_key[i[kit_pkg::RID_W-1:0]] == key) begin
            tbl_valid[i[kit_pkg::RID_W-1:0]] = 1'b0;
            if (tbl_active > 0) tbl_active--;
            push_result(kit_pkg::STAT_OK, i[kit_pkg::RID_W-1:0], 1'b0,
                        tbl_notify[i[kit_pkg::RID_W-1:0]]);
            n++;
            key_clears++;
          end
        end
        if (n == 0) push_result(kit_pkg::STAT_NONE, '0, 1'b0, 1'b0);
      end
      default: begin
        if (id >= tbl_count) push_result(kit_pkg::STAT_RANGE, '0, 1'b0, 1'b0);
        else push_result(kit_pkg::STAT_OK, '0, tbl_valid[id[kit_pkg::RID_W-1:0]], 1'b0);
      end
    endcase
    expected_results[expected_results.size()-1].last = 1'b1;
  endfunction

  task automatic send_item(input logic [kit_pkg::FUNC_W-1:0] fn,
                           input logic [kit_pkg::KIND_W-1:0] kind,
                           input logic [kit_pkg::PAYLD_W-1:0] key, input logic cb,
                           input logic [kit_pkg::EID_W-1:0] id);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {{(kit_pkg::IN_DW - kit_pkg::EID_W - 1 - kit_pkg::PAYLD_W
                    - kit_pkg::KIND_W){1'b0}}, id, cb, key, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_table(fn, kind, key, cb, id);
    func_counts[fn]++;
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_table();
    send_item(kit_pkg::FN_QUERY, 4'd0, '0, 1'b0, 7'd0);
    send_item(kit_pkg::FN_INV_ID, 4'd0, '0, 1'b0, 7'd127);
    send_item(kit_pkg::FN_INV_KEY, 4'd0, '0, 1'b0, 7'd0);
    send_item(kit_pkg::FN_REGISTER, 4'd0, '0, 1'b0, 7'd0);
  endtask

  task automatic test_basic_ops();
    send_item(kit_pkg::FN_REGISTER, 4'd15, '1, 1'b1, 7'd0);
    send_item(kit_pkg::FN_REGISTER, 4'd9, 56'h5A_A55A_A55A_A55A, 1'b0, 7'd0);
    send_item(kit_pkg::FN_REGISTER, 4'd15, '1, 1'b0, 7'd0);
    send_item(kit_pkg::FN_REGISTER, 4'd15, '1, 1'b1, 7'd0);
    send_item(kit_pkg::FN_QUERY, 4'd0, '0, 1'b0, 7'd0);
    send_item(kit_pkg::FN_QUERY, 4'd0, '0, 1'b0, 7'd5);
    send_item(kit_pkg::FN_QUERY, 4'd0, '0, 1'b0, 7'd127);
    send_item(kit_pkg::FN_INV_ID, 4'd0, '0, 1'b1, 7'd1);
    send_item(kit_pkg::FN_INV_ID, 4'd0, '0, 1'b0, 7'd1);
    send_item(kit_pkg::FN_QUERY, 4'd0, '0, 1'b0, 7'd1);
    send_item(kit_pkg::FN_INV_KEY, 4'd15, '1, 1'b0, 7'd0);
    send_item(kit_pkg::FN_INV_KEY, 4'd15, '1, 1'b0, 7'd0);
    send_item(kit_pkg::FN_INV_KEY, 4'd9, 56'h5A_A55A_A55A_A55B, 1'b0, 7'd0);
    send_item(kit_pkg::FN_INV_KEY, 4'd9, 56'h5A_A55A_A55A_A55A, 1'b0, 7'd0);
    send_item(kit_pkg::FN_INV_ID, 4'd0, '0, 1'b0, 7'd4);
    send_item(kit_pkg::FN_REGISTER, 4'd10, 56'hA5_5AA5_5AA5_5AA5, 1'b1, 7'd0);
    send_item(kit_pkg::FN_INV_KEY, 4'd11, 56'hA5_5AA5_5AA5_5AA5, 1'b0, 7'd0);
    send_item(kit_pkg::FN_INV_KEY, 4'd10, 56'hA5_5AA5_5AA5_5AA5, 1'b0, 7'd0);
  endtask

  task automatic test_stall_pressure();
    wait_for_drain();
    rx_hold = PRESSURE_HOLD;
    for (int i = 0; i < 16; i++) begin
      send_item(i[1:0], 4'd3, 56'h33, i[0], i[6:0]);
    end
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [kit_pkg::KIND_W-1:0]  pool_kind[8];
    logic [kit_pkg::PAYLD_W-1:0] pool_key[8];
    logic [kit_pkg::FUNC_W-1:0]  fn;
    logic [kit_pkg::KIND_W-1:0]  kind;
    logic [kit_pkg::PAYLD_W-1:0] key;
    logic [kit_pkg::EID_W-1:0]   id;
    int                          sel;
    int                          pick;
    for (int i = 0; i < 8; i++) begin
      pool_kind[i] = kit_pkg::KIND_W'($urandom_range(0, 15));
      pool_key[i]  = kit_pkg::PAYLD_W'({$urandom, $urandom});
    end
    for (int i = 0; i < n_items; i++) begin
      if (i % 25 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      sel  = $urandom_range(0, 99);
      pick = $urandom_range(0, 7);
      if ($urandom_range(0, 4) == 0) begin
        kind = kit_pkg::KIND_W'($urandom_range(0, 15));
        key  = kit_pkg::PAYLD_W'({$urandom, $urandom});
      end else begin
        kind = pool_kind[pick[2:0]];
        key  = pool_key[pick[2:0]];
      end
      if ($urandom_range(0, 4) == 0) id = kit_pkg::EID_W'($urandom_range(0, 127));
      else id = kit_pkg::EID_W'($urandom_range(0, tbl_count));
      if (sel < 35) fn = kit_pkg::FN_REGISTER;
      else if (sel < 55) fn = kit_pkg::FN_INV_ID;
      else if (sel < 75) fn = kit_pkg::FN_INV_KEY;
      else fn = kit_pkg::FN_QUERY;
      send_item(fn, kind, key, 1'($urandom_range(0, 1)), id);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_table_full();
    while (tbl_count < TABLE_DEPTH) begin
      send_item(kit_pkg::FN_REGISTER, 4'd6, 56'hC0FFEE, 1'($urandom_range(0, 1)), 7'd0);
    end
    send_item(kit_pkg::FN_REGISTER, 4'd6, 56'hC0FFEE, 1'b1, 7'd0);
    send_item(kit_pkg::FN_REGISTER, 4'd0, '1, 1'b0, 7'd0);
    send_item(kit_pkg::FN_QUERY, 4'd0, '0, 1'b0, 7'd63);
    send_item(kit_pkg::FN_QUERY, 4'd0, '0, 1'b0, 7'd64);
    send_item(kit_pkg::FN_INV_ID, 4'd0, '0, 1'b0, 7'd63);
    send_item(kit_pkg::FN_INV_KEY, 4'd6, 56'hC0FFEE, 1'b0, 7'd0);
    send_item(kit_pkg::FN_INV_KEY, 4'd6, 56'hC0FFEE, 1'b0, 7'd0);
    send_item(kit_pkg::FN_INV_ID, 4'd0, '0, 1'b0, 7'd64);
  endtask

  initial begin
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result.status = out_tuser;
      got_result.rid    = out_tdata[5:0];
      got_result.vbit   = out_tdata[6];
      got_result.notify = out_tdata[7];
      got_result.active = out_tdata[14:8];
      got_result.last   = out_tlast;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
          $display("Unexpected result %0d: status=%0d id=%0d valid=%0d notify=%0d",
                   results_seen, got_result.status, got_result.rid, got_result.vbit,
                   got_result.notify);
          $display("  active=%0d last=%0d", got_result.active, got_result.last);
        end
      end else begin
        want_result = expected_results.pop_front();
        if (got_result !== want_result) begin
          mismatches++;
          if (mismatches <= PRINT_LIMIT) begin
            $display("Mismatch on result %0d:", results_seen);
            $display("  expected status=%0d id=%0d valid=%0d notify=%0d active=%0d last=%0d",
                     want_result.status, want_result.rid, want_result.vbit,
                     want_result.notify, want_result.active, want_result.last);
            $display("  actual   status=%0d id=%0d valid=%0d notify=%0d active=%0d last=%0d",
                     got_result.status, got_result.rid, got_result.vbit,
                     got_result.notify, got_result.active, got_result.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction.", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    tbl_count    = 0;
    tbl_active   = 0;
    mismatches   = 0;
    results_seen = 0;
    quiet_cycles = 0;
    key_clears   = 0;
    full_hits    = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    rx_hold      = 0;
    for (int i = 0; i < 4; i++) func_counts[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_basic_ops();
    test_stall_pressure();
    test_random_traffic(260);
    test_table_full();

    wait_for_drain();
    repeat (20) @(posedge clk);

    $display("Ran %0d register, %0d id invalidate, %0d key invalidate and %0d query items.",
             func_counts[kit_pkg::FN_REGISTER], func_counts[kit_pkg::FN_INV_ID],
             func_counts[kit_pkg::FN_INV_KEY], func_counts[kit_pkg::FN_QUERY]);
    $display("Checked %0d results; key scans cleared %0d entries, %0d registers found it full.",
             results_seen, key_clears, full_hits);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
